// ===== src/rsma_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, state types and control structs for the boxcar moving average.
// Used by rsma_ring, rsma_div and running_sum_moving_average_top.
package rsma_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 41;
  localparam int QUOT_W    = 32;
  localparam int CFG_W     = 10;
  localparam int MAX_DEPTH = 512;

  localparam int POS_W = $clog2(MAX_DEPTH);
  localparam int EFF_W = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W = (CFG_W > EFF_W) ? CFG_W : EFF_W;
  localparam int CNT_W = $clog2(SUM_W);

  localparam int APB_DW    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_DEPTH = '0;
  localparam logic [CFG_W-1:0]     DEPTH_RESET      = CFG_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV
  } top_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIX,
    DV_DONE
  } div_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } div_ctrl_t;

endpackage

// ===== src/running_sum_moving_average_top.sv =====
`timescale 1ns / 1ps
// Boxcar moving average over a window of signed 32-bit samples, with APB depth register.
// Depends on rsma_pkg, rsma_ring and rsma_div.
//
// One request is processed at a time. After acceptance come the ring read and
// read-modify-write, the divider start, the bit-serial divider (one quotient bit per cycle
// over the 41-bit sum), saturation and the load of the output register; only then is the
// next request accepted. The result waits in an output register, so the next request is
// taken even while out_stall holds it. The ring needs no clearing after reset: a fill
// count marks which entries were written and the others read as zero. window_depth (byte
// address 0) of 0 acts as 1, values above 512 act as 512; write it only while the block
// is idle.
module running_sum_moving_average_top
  import rsma_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SUM_W-1:0]    out_window_sum,
  output logic signed [QUOT_W-1:0]   out_average,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic        [ADDR_W-1:0]   paddr,
  input  logic        [APB_DW-1:0]   pwdata,
  output logic        [APB_DW-1:0]   prdata,
  output logic                       pready
);

  top_state_t               state_r;
  top_state_t               state_nxt;
  logic [CFG_W-1:0]         depth_cfg_r;
  logic [CMP_W-1:0]         depth_ext;
  logic [EFF_W-1:0]         depth_eff;
  logic                     in_acc;
  logic                     out_free;
  logic                     load_out;
  logic                     sum_vld;
  logic signed [SUM_W-1:0]  ring_sum;
  logic                     res_vld;
  logic signed [QUOT_W-1:0] quotient;
  div_ctrl_t                div_ctrl;
  logic                     out_valid_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic signed [QUOT_W-1:0] out_avg_r;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_WINDOW_DEPTH) ? APB_DW'(depth_cfg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_cfg_r <= DEPTH_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_WINDOW_DEPTH) begin
      depth_cfg_r <= pwdata[CFG_W-1:0];
    end
  end

  assign depth_ext = CMP_W'(depth_cfg_r);
  assign depth_eff = (depth_ext == '0)                    ? EFF_W'(1) :
                     (depth_ext > CMP_W'(MAX_DEPTH))      ? EFF_W'(MAX_DEPTH) :
                                                            EFF_W'(depth_ext);

  // control
  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SUM;
      ST_SUM:  if (sum_vld) state_nxt = ST_DIV;
      ST_DIV:  if (res_vld && out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    div_ctrl.start = (state_r == ST_SUM) && sum_vld;
    div_ctrl.take  = (state_r == ST_DIV) && res_vld && out_free;
    load_out       = div_ctrl.take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  rsma_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_acc),
    .sample  (in_sample),
    .depth   (depth_eff),
    .sum_vld (sum_vld),
    .sum     (ring_sum)
  );

  rsma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (ring_sum),
    .divisor  (depth_eff),
    .res_vld  (res_vld),
    .quotient (quotient)
  );

  // output register; the ring sum holds until the next request is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sum_r <= ring_sum;
      out_avg_r <= quotient;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_sum = out_sum_r;
  assign out_average    = out_avg_r;

endmodule

// ===== src/rsma_ring.sv =====
`timescale 1ns / 1ps
// Sample ring memory with running-sum read-modify-write, write position and fill count.
// Depends on rsma_pkg.
module rsma_ring
  import rsma_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [EFF_W-1:0]    depth,
  output logic                       sum_vld,
  output logic signed [SUM_W-1:0]    sum
);

  logic signed [SAMPLE_W-1:0] ring_mem [MAX_DEPTH];

  logic        [POS_W-1:0]    pos_r;
  logic        [POS_W-1:0]    pos_nxt;
  logic        [EFF_W-1:0]    fill_r;
  logic        [EFF_W-1:0]    fill_nxt;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic                       rmw_r;
  logic                       sum_vld_r;
  logic        [POS_W-1:0]    rpos_r;
  logic        [POS_W-1:0]    rpos;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic signed [SAMPLE_W-1:0] old_smp;

  // wrap to zero when the position is at or beyond the window
  assign rpos = (EFF_W'(pos_r) >= depth) ? '0 : pos_r;

  // entries past the fill count were never written and read as zero
  assign old_smp  = (EFF_W'(rpos_r) < fill_r) ? rdata_r : '0;
  assign sum_nxt  = sum_r + SUM_W'(sample_r) - SUM_W'(old_smp);
  assign fill_nxt = (EFF_W'(rpos_r) == fill_r) ? fill_r + EFF_W'(1) : fill_r;
  assign pos_nxt  = rpos_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (req) begin
      rdata_r  <= ring_mem[rpos];
      rpos_r   <= rpos;
      sample_r <= sample;
    end
    if (rmw_r) begin
      ring_mem[rpos_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      rmw_r     <= 1'b0;
      sum_vld_r <= 1'b0;
    end else begin
      rmw_r     <= req;
      sum_vld_r <= rmw_r;
      if (rmw_r) begin
        pos_r  <= pos_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  assign sum_vld = sum_vld_r;
  assign sum     = sum_r;

endmodule

// ===== src/rsma_div.sv =====
`timescale 1ns / 1ps
// Bit-serial signed divider: window sum by depth, truncated toward zero, saturated to 32 bits.
// Depends on rsma_pkg.
module rsma_div
  import rsma_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  div_ctrl_t                ctrl,
  input  logic signed [SUM_W-1:0]  dividend,
  input  logic        [EFF_W-1:0]  divisor,
  output logic                     res_vld,
  output logic signed [QUOT_W-1:0] quotient
);

  localparam logic [SUM_W-1:0] QLIM = SUM_W'(1) << (QUOT_W - 1);

  div_state_t               state_r;
  div_state_t               state_nxt;
  logic                     neg_r;
  logic [SUM_W-1:0]         mag_r;
  logic [EFF_W-1:0]         rem_r;
  logic [EFF_W-1:0]         div_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [QUOT_W-1:0] quot_r;
  logic [EFF_W:0]           rem_sh;
  logic                     ge;
  logic [EFF_W:0]           rem_sub;

  assign rem_sh  = {rem_r, mag_r[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (ctrl.start) state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == '0) state_nxt = DV_FIX;
      DV_FIX:  state_nxt = DV_DONE;
      DV_DONE: if (ctrl.take) state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    res_vld = (state_r == DV_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE: begin
        if (ctrl.start) begin
          neg_r <= dividend[SUM_W-1];
          mag_r <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
          rem_r <= '0;
          div_r <= divisor;
          cnt_r <= CNT_W'(SUM_W - 1);
        end
      end
      DV_RUN: begin
        // one quotient bit per cycle, shifted into the dividend register
        rem_r <= ge ? rem_sub[EFF_W-1:0] : rem_sh[EFF_W-1:0];
        mag_r <= {mag_r[SUM_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      DV_FIX: begin
        if (neg_r) begin
          quot_r <= (mag_r > QLIM) ? {1'b1, {(QUOT_W-1){1'b0}}}
                                   : QUOT_W'(SUM_W'(0) - mag_r);
        end else begin
          quot_r <= (mag_r >= QLIM) ? {1'b0, {(QUOT_W-1){1'b1}}}
                                    : QUOT_W'(mag_r);
        end
      end
      DV_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign quotient = quot_r;

endmodule

// ===== verif/rsma_window_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the boxcar moving average: keeps its own ring, running sum and depth,
// predicts window_sum and average per accepted request and compares each accepted result.
// Depends on rsma_pkg; instantiated by running_sum_moving_average_top_tb.
module rsma_window_checker
  import rsma_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SUM_W-1:0]    out_window_sum,
  input  logic signed [QUOT_W-1:0]   out_average,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic        [ADDR_W-1:0]   paddr,
  input  logic        [APB_DW-1:0]   pwdata,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic signed [SUM_W-1:0]  window_sum;
    logic signed [QUOT_W-1:0] average;
  } window_result_t;

  localparam longint AVG_MAX = 64'sd2147483647;
  localparam longint AVG_MIN = -64'sd2147483648;

  logic signed [SAMPLE_W-1:0] ring_copy [MAX_DEPTH];
  int unsigned                slot;
  logic signed [SUM_W-1:0]    sum_copy;
  logic        [CFG_W-1:0]    depth_reg;
  window_result_t             results_due [$];
  window_result_t             due;

  function automatic window_result_t advance_window(logic signed [SAMPLE_W-1:0] s);
    int unsigned                eff;
    logic signed [SAMPLE_W-1:0] displaced;
    longint                     sum64;
    longint                     quot;
    window_result_t             r;
    eff = depth_reg;
    if (eff == 0) eff = 1;
    if (eff > MAX_DEPTH) eff = MAX_DEPTH;
    if (slot >= eff) slot = 0;
    displaced = ring_copy[slot];
    ring_copy[slot] = s;
    slot++;
    sum64 = longint'(sum_copy) + longint'(s) - longint'(displaced);
    sum_copy = sum64[SUM_W-1:0];
    // truncating divide, then clamp: only a shrunken window can push it out of range
    quot = longint'(sum_copy) / longint'(eff);
    if (quot > AVG_MAX) quot = AVG_MAX;
    if (quot < AVG_MIN) quot = AVG_MIN;
    r.window_sum = sum_copy;
    r.average = quot[QUOT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DEPTH; i++) ring_copy[i] = '0;
      slot = 0;
      sum_copy = '0;
      depth_reg = DEPTH_RESET;
      results_due.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_WINDOW_DEPTH)
        depth_reg = pwdata[CFG_W-1:0];
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: window_sum %0d average %0d", out_window_sum, out_average);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          if (out_window_sum !== due.window_sum) begin
            $error("window_sum expected %0d actual %0d", due.window_sum, out_window_sum);
            fail_count++;
          end
          if (out_average !== due.average) begin
            $error("average expected %0d actual %0d", due.average, out_average);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) results_due.push_back(advance_window(in_sample));
      pending = results_due.size();
    end
  end

endmodule

// ===== verif/running_sum_moving_average_top_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for running_sum_moving_average_top: directed window cases, then
// random depth phases with random idling. Depends on rsma_pkg and rsma_window_checker.
module running_sum_moving_average_top_tb
  import rsma_pkg::*;
();

  localparam int TARGET_SAMPLES = 2000;
  localparam int IDLE_LIMIT     = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 60;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SUM_W-1:0]    out_window_sum;
  logic signed [QUOT_W-1:0]   out_average;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic        [ADDR_W-1:0]   paddr;
  logic        [APB_DW-1:0]   pwdata;
  logic        [APB_DW-1:0]   prdata;
  logic                       pready;

  int   fail_count;
  int   pending;
  int   sent_total;
  int   phase_left;
  int   stuck_cycles;
  logic held_off;
  logic steady_run;

  assign steady_run = (sent_total >= 1000) && (sent_total < 1300);

  running_sum_moving_average_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_sum (out_window_sum),
    .out_average    (out_average),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  rsma_window_checker window_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_sum (out_window_sum),
    .out_average    (out_average),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("running_sum_moving_average_top verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    while (!steady_run && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    sent_total++;
    phase_left--;
    @(negedge clk);
  endtask

  task automatic write_depth(input logic [CFG_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_DEPTH, 2'b00};
    pwdata  <= APB_DW'(d);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain every outstanding result before touching the depth register.
  task automatic settle_and_set_depth(input logic [CFG_W-1:0] d);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    write_depth(d);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SAMPLE_W'($urandom_range(200)) - 100;
      3:       return {SAMPLE_W{1'b1}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_depth();
    case ($urandom_range(9))
      0:       return CFG_W'(1);
      1:       return CFG_W'(MAX_DEPTH);
      2:       return '0;
      3:       return '1;
      4:       return CFG_W'(MAX_DEPTH + 1);
      5, 6:    return CFG_W'($urandom_range(2, 16));
      7:       return CFG_W'($urandom_range(1, MAX_DEPTH));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // Result side: random stalls, one long hold-off while the sender keeps offering.
  initial begin
    out_stall = 1'b0;
    held_off  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && sent_total >= 700 && phase_left >= 20) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= !steady_run && ($urandom_range(99) < 11);
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sent_total   = 0;
    phase_left   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset depth, field extremes
    push_sample(S_MAX);
    push_sample(S_MIN);
    push_sample('0);
    push_sample({SAMPLE_W{1'b1}});
    push_sample(SAMPLE_W'(1));
    settle_and_set_depth(CFG_W'(2));
    push_sample(S_MAX);
    push_sample(S_MAX);
    // shrink to one: stale entries stay in the sum, average clamps high
    settle_and_set_depth(CFG_W'(1));
    push_sample(S_MAX);
    push_sample(S_MIN);
    settle_and_set_depth(CFG_W'(2));
    push_sample(S_MIN);
    // zero depth acts as one; average clamps low
    settle_and_set_depth('0);
    push_sample(S_MIN);
    push_sample(S_MAX);
    // above the maximum acts as the maximum
    settle_and_set_depth('1);
    push_sample(S_MAX);
    push_sample(SAMPLE_W'(5));
    settle_and_set_depth(CFG_W'(MAX_DEPTH));
    push_sample(S_MIN);

    while (sent_total < TARGET_SAMPLES) begin
      settle_and_set_depth(draw_depth());
      phase_left = $urandom_range(40, 250);
      while (phase_left > 0) push_sample(draw_sample());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("running_sum_moving_average_top verification clean");
    end else begin
      $display("running_sum_moving_average_top verification failed");
    end
    $finish;
  end

endmodule
